>>> rtl/size_class_free_list_allocator_unit_defines.svh
// Assertion macros for the size-class free-list allocator.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define SCFA_ASSERT_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication
`define SCFA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SCFA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/scfa_pkg.sv
// Shared types and constants for the size-class free-list allocator.
// No dependencies; imported by the top level and the sizer.
package scfa_pkg;

   // Sizing of the allocator
   localparam int POOL_BYTES  = 4194304;
   localparam int POOL_COUNT  = 16;
   localparam int STACK_DEPTH = 256;
   localparam int CLASS_COUNT = 11;
   localparam int MIN_BLOCK   = 4;

   // Field widths
   localparam int OP_W     = 1;
   localparam int COUNT_W  = 16;
   localparam int ADDR_W   = 26;
   localparam int STATUS_W = 3;
   localparam int CLASS_W  = 4;
   localparam int LIMIT_W  = 12;
   localparam int ELEM_W   = 9;

   // Derived widths
   localparam int PROD_W      = COUNT_W + ELEM_W;
   localparam int OFFSET_BITS = $clog2(POOL_BYTES);
   localparam int OFS_W       = OFFSET_BITS + 1;
   localparam int POOL_IDX_W  = $clog2(POOL_COUNT) + 1;
   localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
   localparam int STK_IW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int BLOCK_W     = CLASS_COUNT + 2;
   localparam int MEM_DEPTH   = CLASS_COUNT * STACK_DEPTH;
   localparam int MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // Register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = LIMIT_W;
   localparam logic [CSR_IDX_W-1:0] REG_LARGE_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ELEMENT_BYTES = 1'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2048;
   localparam logic [ELEM_W-1:0]  ELEM_RESET  = 9'd4;

   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_REUSED      = 3'd0,
      STAT_BUMPED      = 3'd1,
      STAT_LARGE_ALLOC = 3'd2,
      STAT_FREED       = 3'd3,
      STAT_LARGE_FREE  = 3'd4,
      STAT_NO_POOL     = 3'd5,
      STAT_STACK_FULL  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_POP
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COUNT_W-1:0] elem_count;
      logic [ADDR_W-1:0]  block_addr;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  result_addr;
      logic [CLASS_W-1:0] size_class;
   } rsp_type;

   // Sizer result handed to the control logic
   typedef struct packed {
      logic               is_large;
      logic [CLASS_W-1:0] size_class;
   } size_info_type;

endpackage

>>> rtl/size_class_free_list_allocator_unit.sv
// Top level of the size-class free-list allocator: registers, control, bump pool.
// Depends on scfa_pkg, scfa_sizer, scfa_stack_ram and the assertion macro header.
//
// Usage:
//  req_* carries one allocate or free transaction (op, elem_count, block_addr);
//  it is taken at a clock edge with req_valid high and req_stall low.
//  rsp_* returns exactly one result (status, result_addr, size_class) per
//  request, taken at an edge with rsp_valid high and rsp_stall low.
//  csr_* writes large_limit_bytes (index 0) or element_bytes (index 1).
//  The result is registered from the EXEC state, or from POP for a stack pop.
//  No new request is taken until the current one has loaded its result:
//  the control sequencer holds one transaction at a time and a pop waits
//  on the stack RAM read.
//  A finished result sits in the output register; a new request is taken
//  while it waits, and the next result is held back until the slot drains.
//  Reset (synchronous, active high) empties every class stack, rewinds the
//  bump pointer to pool 0 offset 0 and restores the register defaults.
//  Stack RAM contents are not cleared; only entries below a fill count are read.
`include "size_class_free_list_allocator_unit_defines.svh"

module size_class_free_list_allocator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  scfa_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output scfa_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [scfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scfa_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import scfa_pkg::*;

   // Configuration registers
   logic [LIMIT_W-1:0] limit_ff;
   logic [ELEM_W-1:0]  elem_bytes_ff;

   // Control and allocator state
   state_type             state_ff, state_in;
   logic [FILL_W-1:0]     fill_ff [CLASS_COUNT];
   logic [POOL_IDX_W-1:0] pool_index_ff, pool_index_in;
   logic [OFS_W-1:0]      pool_offset_ff, pool_offset_in;

   // Transaction held during execution
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] addr_ff;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Internal controls
   logic              accept;
   logic              out_free;
   logic              load_rsp;
   logic              commit;
   logic              do_push;
   logic              do_pop;
   logic              bump_ok;
   size_info_type     info;
   logic [FILL_W-1:0] fill_cur;
   logic [BLOCK_W-1:0] block_bytes;
   logic [OFS_W:0]    need_sum;
   logic [OFS_W:0]    fit_sum;
   logic [POOL_IDX_W-1:0] idx_try;
   logic [OFS_W-1:0]  ofs_try;
   logic [STK_IW-1:0] top_idx;
   logic [MEM_AW-1:0] mem_addr;
   logic [ADDR_W-1:0] rd_data;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         elem_bytes_ff <= ELEM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_LARGE_LIMIT:   limit_ff      <= csr_wr_data[LIMIT_W-1:0];
            REG_ELEMENT_BYTES: elem_bytes_ff <= csr_wr_data[ELEM_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_data.op;
         addr_ff <= req_data.block_addr;
      end
   end

   scfa_sizer u_sizer (
      .clock         (clock),
      .load          (accept),
      .elem_count    (req_data.elem_count),
      .element_bytes (elem_bytes_ff),
      .large_limit   (limit_ff),
      .info          (info)
   );

   // Stack addressing: class base plus slot
   assign fill_cur = fill_ff[info.size_class];
   assign top_idx  = do_pop ? STK_IW'(fill_cur - FILL_W'(1)) : STK_IW'(fill_cur);
   assign mem_addr = MEM_AW'(info.size_class) * MEM_AW'(STACK_DEPTH) + MEM_AW'(top_idx);

   scfa_stack_ram #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (ADDR_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (mem_addr),
      .wr_data (addr_ff),
      .rd_en   (do_pop),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   // Bump allocation: open the next pool when the block does not fit
   always_comb begin
      block_bytes = BLOCK_W'(MIN_BLOCK) << info.size_class;
      need_sum    = (OFS_W + 1)'(pool_offset_ff) + (OFS_W + 1)'(block_bytes);
      idx_try     = pool_index_ff;
      ofs_try     = pool_offset_ff;
      if (need_sum > (OFS_W + 1)'(POOL_BYTES) &&
          (pool_index_ff + POOL_IDX_W'(1)) < POOL_IDX_W'(POOL_COUNT)) begin
         idx_try = pool_index_ff + POOL_IDX_W'(1);
         ofs_try = '0;
      end
      fit_sum = (OFS_W + 1)'(ofs_try) + (OFS_W + 1)'(block_bytes);
      bump_ok = fit_sum <= (OFS_W + 1)'(POOL_BYTES);
   end

   // Sequencer: next state, result and state updates
   always_comb begin
      state_in       = state_ff;
      load_rsp       = 1'b0;
      commit         = 1'b0;
      do_push        = 1'b0;
      do_pop         = 1'b0;
      pool_index_in  = pool_index_ff;
      pool_offset_in = pool_offset_ff;
      rsp_data_in.status      = STAT_REUSED;
      rsp_data_in.result_addr = '0;
      rsp_data_in.size_class  = info.size_class;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!info.is_large && op_ff == OP_ALLOC && fill_cur != '0) begin
               // reuse: read the top of the class stack
               do_pop   = 1'b1;
               state_in = S_POP;
            end else if (out_free) begin
               load_rsp = 1'b1;
               commit   = 1'b1;
               state_in = S_IDLE;
               if (info.is_large) begin
                  rsp_data_in.status     = (op_ff == OP_FREE) ? STAT_LARGE_FREE
                                                              : STAT_LARGE_ALLOC;
                  rsp_data_in.size_class = '0;
               end else if (op_ff == OP_FREE) begin
                  if (fill_cur < FILL_W'(STACK_DEPTH)) begin
                     do_push            = 1'b1;
                     rsp_data_in.status = STAT_FREED;
                  end else begin
                     rsp_data_in.status = STAT_STACK_FULL;
                  end
               end else if (bump_ok) begin
                  pool_index_in           = idx_try;
                  pool_offset_in          = ofs_try + OFS_W'(block_bytes);
                  rsp_data_in.status      = STAT_BUMPED;
                  rsp_data_in.result_addr = (ADDR_W'(idx_try) << OFFSET_BITS) |
                                            ADDR_W'(ofs_try);
               end else begin
                  rsp_data_in.status = STAT_NO_POOL;
               end
            end
         end
         S_POP: begin
            if (out_free) begin
               load_rsp                = 1'b1;
               state_in                = S_IDLE;
               rsp_data_in.status      = STAT_REUSED;
               rsp_data_in.result_addr = rd_data;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pool pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_index_ff  <= '0;
         pool_offset_ff <= '0;
      end else if (commit) begin
         pool_index_ff  <= pool_index_in;
         pool_offset_ff <= pool_offset_in;
      end
   end

   // Per-class fill counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CLASS_COUNT; c++) begin
            fill_ff[c] <= '0;
         end
      end else if (do_push) begin
         fill_ff[info.size_class] <= fill_cur + FILL_W'(1);
      end else if (do_pop) begin
         fill_ff[info.size_class] <= fill_cur - FILL_W'(1);
      end
   end

   // Output register
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `SCFA_ASSERT_NEXT(a_accept_to_exec, accept, state_ff == S_EXEC, "accept did not start execution")
   `SCFA_ASSERT_HOLDS(a_pool_index_range, pool_index_ff < POOL_IDX_W'(POOL_COUNT), "pool index out of range")
   `SCFA_ASSERT_HOLDS(a_pool_offset_range, pool_offset_ff <= OFS_W'(POOL_BYTES), "pool offset past pool end")
   `SCFA_ASSERT_IMPLIES(a_large_clean, rsp_valid && (rsp_data.status == STAT_LARGE_ALLOC || rsp_data.status == STAT_LARGE_FREE), rsp_data.size_class == '0 && rsp_data.result_addr == '0, "large result carries class or address")

endmodule

>>> rtl/scfa_stack_ram.sv
// Simple dual-port synchronous RAM holding the per-class free stacks.
// One write and one registered read per cycle; no package dependency.
module scfa_stack_ram #(
   parameter int DEPTH = 2816,
   parameter int WIDTH = 26
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/scfa_sizer.sv
// Request sizer: registers count times element size, then finds the size class.
// Depends on scfa_pkg.
module scfa_sizer (
   input  logic                          clock,
   input  logic                          load,
   input  logic [scfa_pkg::COUNT_W-1:0]  elem_count,
   input  logic [scfa_pkg::ELEM_W-1:0]   element_bytes,
   input  logic [scfa_pkg::LIMIT_W-1:0]  large_limit,
   output scfa_pkg::size_info_type       info
);
   import scfa_pkg::*;

   logic [PROD_W-1:0]      total_ff;
   logic [PROD_W-1:0]      total_in;
   logic [CLASS_COUNT-1:0] below;

   // Byte count of the transaction, captured at accept
   assign total_in = PROD_W'(elem_count) * PROD_W'(element_bytes);

   always_ff @(posedge clock) begin
      if (load) begin
         total_ff <= total_in;
      end
   end

   // Class index = number of class sizes that are still too small
   always_comb begin
      for (int j = 0; j < CLASS_COUNT; j++) begin
         below[j] = (PROD_W'(MIN_BLOCK) << j) < total_ff;
      end
      info.size_class = CLASS_W'($countones(below));
      info.is_large   = (total_ff > PROD_W'(large_limit)) || below[CLASS_COUNT-1];
   end

endmodule
